@@ hw/rtl/tcth_pkg.sv @@
// shared types and constants for the touch contact tap/hold tracker
`default_nettype none
package tcth_pkg;

    localparam int unsigned MAX_CONTACTS_DEF = 5;
    localparam logic [15:0] HOLD_RESET = 16'd500;
    localparam logic [9:0]  MOVE_RESET = 10'd30;

    // command codes
    localparam logic [1:0] CMD_POLL   = 2'd0;
    localparam logic [1:0] CMD_RECORD = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;

    // register indexes
    localparam logic [0:0] REG_HOLD = 1'b0;
    localparam logic [0:0] REG_MOVE = 1'b1;

    // one contact slot
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [31:0] t0;
        logic        moved;
        logic        fired;
        logic        edge_f;
    } slot_t;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_in;   // capture the accepted item
        logic clr_scan;   // reset scan indexes, match flag, output index and gone count
        logic scan_live;  // compare input id to live[idx]
        logic store_rec;  // append built record to pending
        logic scan_gone;  // compare live[idx] id against pending[pidx]
        logic next_gone;  // close test of live[idx], step idx
        logic commit;     // pending becomes live
        logic emit;       // load output register from current index
        logic step_out;   // step output index
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       pend_full;
        logic       live_done;  // live scan index reached live count
        logic       pend_done;  // pending scan index reached pending count
        logic       hit;
        logic       out_done;   // no more results in this pass
        logic       out_busy;   // output register holds an item that is not taken
    } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/touch_contact_tap_hold_tracker.sv @@
// top level of the touch contact tap/hold tracker
//
// channel   dir  payload
// s_axis    in   tdata: cmd, contact_id, pos_x, pos_y, now_ms
// m_axis    out  tdata: present, out_x, out_y, is_down, hold_edge, tap_edge,
//                pressed_at_ms; tlast: last
// cfg       in   cfg_index, cfg_data
//
// a record runs a serial id search over the live table
// end of report runs a serial compare of every live id against the pending table,
// then one result item per cycle unless the output stalls, set by the single output register
// reset is synchronous active low; tables need no clearing
// output stalls hold the block in its output phase
`default_nettype none
module touch_contact_tap_hold_tracker #(
    parameter int unsigned MAX_CONTACTS = tcth_pkg::MAX_CONTACTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd[1:0], contact_id[9:2], pos_x[25:10], pos_y[41:26], now_ms[73:42], zero fill
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // present[0], out_x[16:1], out_y[32:17], is_down[33], hold_edge[34],
    // tap_edge[35], pressed_at_ms[67:36], zero fill
    output logic [71:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    tcth_pkg::cmd_t  cmd;
    tcth_pkg::stat_t st;
    logic [67:0]     odata;

    assign cfg_ready = 1'b1;

    tcth_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (s_axis_tvalid && s_axis_tready),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tcth_dp #(.MAX_CONTACTS(MAX_CONTACTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_cmd    (s_axis_tdata[1:0]),
        .in_id     (s_axis_tdata[9:2]),
        .in_x      (s_axis_tdata[25:10]),
        .in_y      (s_axis_tdata[41:26]),
        .in_now    (s_axis_tdata[73:42]),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_val   (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (odata),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, odata};

endmodule
`default_nettype wire

@@ hw/rtl/tcth_ctrl.sv @@
// controller state machine of the tracker
`default_nettype none
module tcth_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_fire,
    output logic                in_ready,
    input  wire tcth_pkg::stat_t st,
    output tcth_pkg::cmd_t      cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DEC  = 7'b0000010,
        S_FIND = 7'b0000100,
        S_GONE = 7'b0001000,
        S_COMM = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_WAIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.latch_in = 1'b1;
                    cmd.clr_scan = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (st.cmd == tcth_pkg::CMD_RECORD) begin
                    state_next = st.pend_full ? S_IDLE : S_FIND;
                end else if (st.cmd == tcth_pkg::CMD_END) begin
                    state_next = S_GONE;
                end else if (st.cmd == tcth_pkg::CMD_POLL) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_FIND: begin
                if (st.live_done || st.hit) begin
                    cmd.store_rec = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.scan_live = 1'b1;
                end
            end
            S_GONE: begin
                if (st.live_done) begin
                    state_next = S_COMM;
                end else if (st.pend_done || st.hit) begin
                    cmd.next_gone = 1'b1;
                end else begin
                    cmd.scan_gone = 1'b1;
                end
            end
            S_COMM: begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!st.out_busy) begin
                    cmd.emit = 1'b1;
                    cmd.step_out = 1'b1;
                    state_next = st.out_done ? S_WAIT : S_OUT;
                end
            end
            S_WAIT: begin
                if (!st.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule
`default_nettype wire

@@ hw/rtl/tcth_dp.sv @@
// datapath of the tracker: contact tables, scans and output register
`default_nettype none
module tcth_dp #(
    parameter int unsigned MAX_CONTACTS = tcth_pkg::MAX_CONTACTS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [1:0]     in_cmd,
    input  wire logic [7:0]     in_id,
    input  wire logic [15:0]    in_x,
    input  wire logic [15:0]    in_y,
    input  wire logic [31:0]    in_now,
    input  wire logic           cfg_we,
    input  wire logic           cfg_idx,
    input  wire logic [15:0]    cfg_val,
    input  wire tcth_pkg::cmd_t cmd,
    output tcth_pkg::stat_t     st,
    input  wire logic           out_ready,
    output logic                out_valid,
    output logic [67:0]         out_data,
    output logic                out_last
);

    localparam int unsigned CW = $clog2(MAX_CONTACTS + 1);
    localparam int unsigned IW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int unsigned OW = $clog2(2 * MAX_CONTACTS + 1);

    logic [15:0] hold_reg;
    logic [9:0]  move_reg;
    logic [1:0]  cmd_reg;
    logic [7:0]  id_reg;
    logic [15:0] x_reg, y_reg;
    logic [31:0] now_reg;

    tcth_pkg::slot_t live_reg [MAX_CONTACTS];
    tcth_pkg::slot_t pend_reg [MAX_CONTACTS];
    tcth_pkg::slot_t gone_reg [MAX_CONTACTS];
    logic [CW-1:0] live_cnt_reg, pend_cnt_reg, gone_cnt_reg;
    logic [CW-1:0] idx_reg, pidx_reg;
    logic          hit_reg;
    logic [OW-1:0] oidx_reg;
    logic          ovalid_reg, olast_reg;
    logic [67:0]   odata_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= tcth_pkg::HOLD_RESET;
            move_reg <= tcth_pkg::MOVE_RESET;
        end else if (cfg_we) begin
            if (cfg_idx == tcth_pkg::REG_HOLD) hold_reg <= cfg_val;
            else                               move_reg <= cfg_val[9:0];
        end
    end

    // captured item
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg <= in_cmd;
            id_reg  <= in_id;
            x_reg   <= in_x;
            y_reg   <= in_y;
            now_reg <= in_now;
        end
    end

    // current scan entries
    tcth_pkg::slot_t live_cur, pend_cur, rec;
    logic [IW-1:0] li, pi;
    assign li = idx_reg[IW-1:0];
    assign pi = pidx_reg[IW-1:0];
    assign live_cur = live_reg[li];
    assign pend_cur = pend_reg[pi];

    // record build: history from hit entry or fresh
    logic [16:0] dx, dy;
    logic [31:0] dt;
    logic        mv;
    always_comb begin
        if (hit_reg) begin
            rec = live_cur;
        end else begin
            rec = '0;
            rec.id = id_reg;
            rec.x0 = x_reg;
            rec.y0 = y_reg;
            rec.t0 = now_reg;
        end
        dx = (x_reg >= rec.x0) ? {1'b0, x_reg - rec.x0} : {1'b0, rec.x0 - x_reg};
        dy = (y_reg >= rec.y0) ? {1'b0, y_reg - rec.y0} : {1'b0, rec.y0 - y_reg};
        mv = hit_reg && ((dx > {7'd0, move_reg}) || (dy > {7'd0, move_reg}));
        rec.moved = rec.moved | mv;
        rec.x = x_reg;
        rec.y = y_reg;
        rec.edge_f = 1'b0;
        dt = now_reg - rec.t0;
        if (!rec.moved && !rec.fired && !dt[31] && (dt >= {16'd0, hold_reg})) begin
            rec.fired = 1'b1;
            rec.edge_f = 1'b1;
        end
    end

    // output selection
    logic [CW-1:0]      lsel, gsel;
    tcth_pkg::slot_t    osl;
    logic               odown, otap, opres, olast_n;
    logic [OW-1:0]      total;
    assign total = OW'(live_cnt_reg) + OW'(gone_cnt_reg);
    always_comb begin
        lsel = oidx_reg[CW-1:0];
        gsel = CW'(oidx_reg - OW'(live_cnt_reg));
        odown = (oidx_reg < OW'(live_cnt_reg));
        osl = odown ? live_reg[lsel[IW-1:0]] : gone_reg[gsel[IW-1:0]];
        opres = (total != '0);
        otap = !odown && !osl.moved && !osl.fired;
        olast_n = (total == '0) || (oidx_reg + OW'(1) >= total);
    end

    // tables and scan counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_cnt_reg <= '0;
            pend_cnt_reg <= '0;
            gone_cnt_reg <= '0;
            idx_reg  <= '0;
            pidx_reg <= '0;
            hit_reg  <= 1'b0;
            oidx_reg <= '0;
        end else begin
            if (cmd.clr_scan) begin
                idx_reg  <= '0;
                pidx_reg <= '0;
                hit_reg  <= 1'b0;
                oidx_reg <= '0;
                gone_cnt_reg <= '0;
            end
            if (cmd.scan_live) begin
                if (live_cur.id == id_reg) hit_reg <= 1'b1;
                else                       idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.store_rec) begin
                pend_reg[pend_cnt_reg[IW-1:0]] <= rec;
                pend_cnt_reg <= pend_cnt_reg + CW'(1);
            end
            if (cmd.scan_gone) begin
                if (pend_cur.id == live_cur.id) hit_reg <= 1'b1;
                else                            pidx_reg <= pidx_reg + CW'(1);
            end
            if (cmd.next_gone) begin
                if (!hit_reg) begin
                    gone_reg[gone_cnt_reg[IW-1:0]] <= live_cur;
                    gone_cnt_reg <= gone_cnt_reg + CW'(1);
                end
                idx_reg  <= idx_reg + CW'(1);
                pidx_reg <= '0;
                hit_reg  <= 1'b0;
            end
            if (cmd.commit) begin
                for (int i = 0; i < MAX_CONTACTS; i++) live_reg[i] <= pend_reg[i];
                live_cnt_reg <= pend_cnt_reg;
                pend_cnt_reg <= '0;
            end
            if (cmd.step_out) begin
                if (odown && opres) live_reg[lsel[IW-1:0]].edge_f <= 1'b0;
                oidx_reg <= oidx_reg + OW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            olast_reg <= olast_n;
            if (opres) begin
                odata_reg <= {osl.t0, otap,
                              odown && (cmd_reg == tcth_pkg::CMD_END) && osl.edge_f,
                              odown, osl.y, osl.x, 1'b1};
            end else begin
                odata_reg <= '0;
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;

    // status
    always_comb begin
        st.cmd       = cmd_reg;
        st.pend_full = (pend_cnt_reg >= CW'(MAX_CONTACTS));
        st.live_done = (idx_reg >= live_cnt_reg);
        st.pend_done = (pidx_reg >= pend_cnt_reg);
        st.hit       = hit_reg;
        st.out_done  = olast_n;
        st.out_busy  = ovalid_reg && !out_ready;
    end

endmodule
`default_nettype wire

@@ hw/rtl/tcth_checker.sv @@
// port-level checker for the tracker, bound to the top level
`default_nettype none
module tcth_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // no new item taken while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");

    // empty-list marker is always the last of its pass
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tlast)
        else $error("empty marker not last");

    // released contacts never carry a hold edge
    a_rel_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[33]) |-> !m_axis_tdata[34])
        else $error("hold edge on released contact");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

endmodule

bind touch_contact_tap_hold_tracker tcth_checker u_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
